@@ rtl/afd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afd_pkg
// Shared types and constants of the start / length / checksum frame receiver.
// ----------------------------------------------------------------------------
package afd_pkg;

   localparam int BUFFER_BYTES = 512;
   localparam logic [15:0] LIMIT_CAP = 16'(BUFFER_BYTES - 4);
   localparam logic [8:0] MAX_LEN_RESET = 9'd508;

   localparam logic [7:0] START_BYTE = 8'h7E;
   localparam logic [7:0] TYPE_TX_STATUS = 8'h8B;
   localparam logic [7:0] TYPE_RX_PACKET = 8'h90;
   localparam logic [15:0] RX_DATA_OFFSET = 16'(1 + 8 + 2 + 1 + 1);

   localparam logic [8:0] IDX_TYPE = 9'd0;
   localparam logic [8:0] IDX_FRAME_ID = 9'd1;
   localparam logic [8:0] IDX_RSSI = 9'd11;
   localparam logic [8:0] IDX_DELIVERY = 9'd12;

   typedef enum logic [2:0] {
      STATUS_TX_OK    = 3'd0,
      STATUS_RX_OK    = 3'd1,
      STATUS_OTHER_OK = 3'd2,
      STATUS_CSUM_ERR = 3'd3,
      STATUS_TOO_LONG = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      PH_HUNT   = 4'b0001,
      PH_LEN_HI = 4'b0010,
      PH_LEN_LO = 4'b0100,
      PH_DATA   = 4'b1000
   } phase_type;

   typedef struct packed {
      status_type  status;
      logic [7:0]  pkt_type;
      logic [15:0] declared_length;
      logic [7:0]  seq_id;
      logic [7:0]  delivery_code;
      logic [7:0]  signal_strength;
      logic [8:0]  payload_length;
   } result_type;

endpackage

@@ rtl/afd_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afd_if
// Byte and result channel interfaces of the frame receiver.
// ----------------------------------------------------------------------------
interface afd_req_if ();
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface afd_rsp_if ();
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [7:0]  pkt_type;
   logic [15:0] declared_length;
   logic [7:0]  seq_id;
   logic [7:0]  delivery_code;
   logic [7:0]  signal_strength;
   logic [8:0]  payload_length;

   modport source (output valid, output status, output pkt_type, output declared_length,
                   output seq_id, output delivery_code, output signal_strength,
                   output payload_length, input ready);
   modport sink (input valid, input status, input pkt_type, input declared_length,
                 input seq_id, input delivery_code, input signal_strength,
                 input payload_length, output ready);
endinterface

@@ rtl/api_frame_deframer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// api_frame_deframer
// Receives a byte stream and reports one checked result per framed packet.
// ----------------------------------------------------------------------------
// channel  port      dir  payload
// byte     req_chan  in   rx_byte
// result   rsp_chan  out  status, pkt_type, declared_length, seq_id,
//                         delivery_code, signal_strength, payload_length
// csr      csr_*     in   max_frame_length (write only)
//
// One byte is taken every cycle unless the output register stalls it; a result shows
// in the output register the cycle after the byte that ends its frame.
// The output register is the only buffer: while it holds an untaken result
// no byte is taken.
// Synchronous reset returns to header hunt with the length limit at 508.
// ----------------------------------------------------------------------------
module api_frame_deframer import afd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   afd_req_if.sink    req_chan,
   afd_rsp_if.source  rsp_chan,
   input  logic       csr_write_enable,
   input  logic [8:0] csr_write_data
);

   logic [8:0] max_len_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff, rsp_in;
   logic       byte_accept;
   logic       result_valid;
   result_type result;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign byte_accept = req_chan.valid && req_chan.ready;

   afd_frame_fsm u_fsm (
      .clock        (clock),
      .reset        (reset),
      .byte_accept  (byte_accept),
      .rx_byte      (req_chan.rx_byte),
      .max_len      (max_len_ff),
      .result_valid (result_valid),
      .result       (result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in = rsp_ff;
      if (result_valid) begin
         rsp_valid_in = 1'b1;
         rsp_in = result;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= MAX_LEN_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            max_len_ff <= csr_write_data;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.status = rsp_ff.status;
   assign rsp_chan.pkt_type = rsp_ff.pkt_type;
   assign rsp_chan.declared_length = rsp_ff.declared_length;
   assign rsp_chan.seq_id = rsp_ff.seq_id;
   assign rsp_chan.delivery_code = rsp_ff.delivery_code;
   assign rsp_chan.signal_strength = rsp_ff.signal_strength;
   assign rsp_chan.payload_length = rsp_ff.payload_length;

endmodule

@@ rtl/afd_frame_fsm.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afd_frame_fsm
// Header hunt, length check, data capture and checksum check, one byte a cycle while bytes are accepted.
// ----------------------------------------------------------------------------
module afd_frame_fsm import afd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        byte_accept,
   input  logic [7:0]  rx_byte,
   input  logic [8:0]  max_len,
   output logic        result_valid,
   output result_type  result
);

   phase_type   phase_ff, phase_in;
   logic [7:0]  len_hi_ff, len_hi_in;
   logic [15:0] length_ff, length_in;
   logic [8:0]  count_ff, count_in;
   logic [7:0]  sum_ff, sum_in;
   logic [7:0]  cap_type_ff, cap_type_in;
   logic [7:0]  cap_id_ff, cap_id_in;
   logic [7:0]  cap_rssi_ff, cap_rssi_in;
   logic [7:0]  cap_dlv_ff, cap_dlv_in;

   logic [15:0] limit;
   logic [15:0] new_length;
   logic [7:0]  ftype;
   logic [7:0]  calc;

   assign limit = ({7'd0, max_len} < LIMIT_CAP) ? {7'd0, max_len} : LIMIT_CAP;
   assign new_length = {len_hi_ff, rx_byte};
   assign ftype = (length_ff == 16'd0) ? rx_byte : cap_type_ff;
   assign calc = 8'hFF - sum_ff;

   always_comb begin
      phase_in = phase_ff;
      len_hi_in = len_hi_ff;
      length_in = length_ff;
      count_in = count_ff;
      sum_in = sum_ff;
      cap_type_in = cap_type_ff;
      cap_id_in = cap_id_ff;
      cap_rssi_in = cap_rssi_ff;
      cap_dlv_in = cap_dlv_ff;
      result_valid = 1'b0;
      result = '0;
      result.status = STATUS_TX_OK;
      if (byte_accept) begin
         unique case (phase_ff)
            PH_HUNT: begin
               if (rx_byte == START_BYTE) begin
                  phase_in = PH_LEN_HI;
               end
            end
            PH_LEN_HI: begin
               len_hi_in = rx_byte;
               phase_in = PH_LEN_LO;
            end
            PH_LEN_LO: begin
               length_in = new_length;
               count_in = '0;
               sum_in = '0;
               if (new_length > limit) begin
                  result_valid = 1'b1;
                  result.status = STATUS_TOO_LONG;
                  result.declared_length = new_length;
                  phase_in = PH_HUNT;
                  cap_type_in = '0;
                  cap_id_in = '0;
                  cap_rssi_in = '0;
                  cap_dlv_in = '0;
               end else begin
                  phase_in = PH_DATA;
               end
            end
            PH_DATA: begin
               if ({7'd0, count_ff} < length_ff) begin
                  priority if (count_ff == IDX_TYPE) begin
                     cap_type_in = rx_byte;
                  end else if (count_ff == IDX_FRAME_ID) begin
                     cap_id_in = rx_byte;
                  end else if (count_ff == IDX_RSSI) begin
                     cap_rssi_in = rx_byte;
                  end else if (count_ff == IDX_DELIVERY) begin
                     cap_dlv_in = rx_byte;
                  end else begin
                  end
                  sum_in = sum_ff + rx_byte;
                  count_in = count_ff + 9'd1;
               end else begin
                  result_valid = 1'b1;
                  result.pkt_type = ftype;
                  result.declared_length = length_ff;
                  priority if (calc != rx_byte) begin
                     result.status = STATUS_CSUM_ERR;
                  end else if (ftype == TYPE_TX_STATUS) begin
                     result.status = STATUS_TX_OK;
                     result.seq_id = (length_ff > 16'd1) ? cap_id_ff : 8'd0;
                     result.delivery_code = (length_ff > 16'd12) ? cap_dlv_ff : 8'd0;
                  end else if (ftype == TYPE_RX_PACKET) begin
                     result.status = STATUS_RX_OK;
                     result.signal_strength = (length_ff > 16'd11) ? cap_rssi_ff : 8'd0;
                     result.payload_length = (length_ff > RX_DATA_OFFSET)
                                           ? 9'(length_ff - RX_DATA_OFFSET) : 9'd0;
                  end else begin
                     result.status = STATUS_OTHER_OK;
                  end
                  phase_in = PH_HUNT;
                  count_in = '0;
                  sum_in = '0;
                  cap_type_in = '0;
                  cap_id_in = '0;
                  cap_rssi_in = '0;
                  cap_dlv_in = '0;
               end
            end
            default: begin
               phase_in = PH_HUNT;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         len_hi_ff <= '0;
         length_ff <= '0;
         count_ff <= '0;
         sum_ff <= '0;
         cap_type_ff <= '0;
         cap_id_ff <= '0;
         cap_rssi_ff <= '0;
         cap_dlv_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         len_hi_ff <= len_hi_in;
         length_ff <= length_in;
         count_ff <= count_in;
         sum_ff <= sum_in;
         cap_type_ff <= cap_type_in;
         cap_id_ff <= cap_id_in;
         cap_rssi_ff <= cap_rssi_in;
         cap_dlv_ff <= cap_dlv_in;
      end
   end

`ifndef SYNTH
   a_result_needs_byte: assert property (@(posedge clock) disable iff (reset)
      result_valid |-> byte_accept)
      else $error("result without byte transfer");

   a_hunt_after_result: assert property (@(posedge clock) disable iff (reset)
      result_valid |=> (phase_ff == PH_HUNT) && (sum_ff == 8'd0) && (count_ff == 9'd0))
      else $error("frame state not cleared after result");

   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DATA) |-> ({7'd0, count_ff} <= length_ff))
      else $error("data count beyond declared length");

   a_data_length_ok: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DATA) |-> (length_ff <= LIMIT_CAP))
      else $error("oversized frame entered data phase");
`endif

endmodule
